FILE: src/wptsp_pkg.sv
package wptsp_pkg;

   // field widths
   localparam int PT_W   = 21;            // Q17.3 point and origin components
   localparam int T_W    = PT_W + 1;      // point minus origin
   localparam int AX_W   = 20;            // Q1.18 axis components
   localparam int PRD_W  = T_W + AX_W;    // one component product
   localparam int DOT_W  = PRD_W + 2;     // sum of three products, signed
   localparam int MAG_W  = DOT_W - 1;     // magnitude of a dot product
   localparam int TAN_W  = 20;            // Q4.16 tangent
   localparam int NUM_W  = MAG_W + TAN_W; // numerator or divisor magnitude
   localparam int K_W    = 13;            // screen half extent in 1/16 pixel
   localparam int PROD_W = NUM_W + K_W;   // numerator times half extent
   localparam int Q_W    = 16;            // quotient bits before saturation
   localparam int REM_W  = NUM_W + Q_W;   // divider remainder
   localparam int SCR_W  = 16;            // screen coordinate
   localparam int CEN_W  = Q_W + 3;       // centre plus or minus quotient

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 63;

   // pipeline depth from accepted command to result strobe
   localparam int LATENCY = 26;

   // screen geometry in 1/16 pixel
   localparam logic [K_W-1:0] HALF_W16 = K_W'(5120);
   localparam logic [K_W-1:0] HALF_H16 = K_W'(3840);
   localparam logic signed [SCR_W-1:0] FULL_W16 = SCR_W'(10240);
   localparam logic signed [SCR_W-1:0] FULL_H16 = SCR_W'(7680);

   // 0.001 in Q.21
   localparam logic signed [DOT_W-1:0] DEPTH_MIN = DOT_W'(2097);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_ORIGIN = 3'd0,
      CSR_FORWARD     = 3'd1,
      CSR_RIGHT       = 3'd2,
      CSR_UP          = 3'd3,
      CSR_TAN_X       = 3'd4,
      CSR_TAN_Y       = 3'd5
   } csr_idx_type;

   // register file as seen by the datapath; axis 0 forward, 1 side, 2 up
   typedef struct packed {
      logic [2:0][PT_W-1:0]       origin;
      logic [2:0][2:0][AX_W-1:0]  axis;
      logic [TAN_W-1:0]           tan_x;
      logic [TAN_W-1:0]           tan_y;
   } cfg_type;

   // per item flags carried alongside the arithmetic
   typedef struct packed {
      logic mode;
      logic visible;
      logic behind;
   } side_type;

   // dot products, 0 forward, 1 side, 2 up
   typedef struct packed {
      logic                       valid;
      logic                       mode;
      logic [2:0][DOT_W-1:0]      dot;
   } front_type;

   typedef struct packed {
      logic [PROD_W-1:0] num;
      logic [NUM_W-1:0]  den;
      logic              neg;
   } dlane_type;

   // lane 0 horizontal, lane 1 vertical
   typedef struct packed {
      logic                 valid;
      side_type             side;
      dlane_type [1:0]      lane;
   } div_in_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] den;
      logic [Q_W-1:0]   quo;
      logic             ovf;
      logic             zero;
      logic             neg;
   } step_type;

   typedef struct packed {
      logic [Q_W:0] quo;
      logic         neg;
   } qlane_type;

   typedef struct packed {
      logic                 valid;
      side_type             side;
      qlane_type [1:0]      lane;
   } div_out_type;

   typedef struct packed {
      logic                     valid;
      logic                     visible;
      logic signed [SCR_W-1:0]  screen_x;
      logic signed [SCR_W-1:0]  screen_y;
   } result_type;

   function automatic logic [MAG_W-1:0] dot_mag(input logic signed [DOT_W-1:0] v);
      logic [DOT_W-1:0] a;
      a = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
      return a[MAG_W-1:0];
   endfunction

endpackage

FILE: src/wptsp_front.sv
module wptsp_front import wptsp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   input  logic                    in_mode,
   input  logic signed [PT_W-1:0]  in_x,
   input  logic signed [PT_W-1:0]  in_y,
   input  logic signed [PT_W-1:0]  in_z,
   output front_type               fo
);

   logic                          v1_ff, v2_ff, v3_ff;
   logic                          m1_ff, m2_ff, m3_ff;
   logic signed [T_W-1:0]         t_ff [3];
   logic signed [T_W-1:0]         t_in [3];
   logic signed [PRD_W-1:0]       p_ff [3][3];
   logic [2:0][DOT_W-1:0]         dot_ff;

   // point minus view origin
   always_comb begin
      t_in[0] = T_W'(in_x) - T_W'($signed(cfg.origin[0]));
      t_in[1] = T_W'(in_y) - T_W'($signed(cfg.origin[1]));
      t_in[2] = T_W'(in_z) - T_W'($signed(cfg.origin[2]));
   end

   // control: valid and mode travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // three stages: difference, component products, sums
   always_ff @(posedge clock) begin
      m1_ff <= in_mode;
      m2_ff <= m1_ff;
      m3_ff <= m2_ff;
      for (int i = 0; i < 3; i++) begin
         t_ff[i] <= t_in[i];
      end
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[a][i] <= t_ff[i] * $signed(cfg.axis[a][i]);
         end
      end
      for (int a = 0; a < 3; a++) begin
         dot_ff[a] <= DOT_W'(p_ff[a][0]) + DOT_W'(p_ff[a][1]) + DOT_W'(p_ff[a][2]);
      end
   end

   assign fo.valid = v3_ff;
   assign fo.mode  = m3_ff;
   assign fo.dot   = dot_ff;

endmodule

FILE: src/wptsp_select.sv
module wptsp_select import wptsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  front_type   fi,
   output div_in_type  dout
);

   logic signed [DOT_W-1:0] df, dr, du;
   logic [MAG_W-1:0]        af, ar, au;

   logic                    v4_ff, v5_ff, v6_ff;
   side_type                s4_ff, s5_ff, s6_ff;
   logic [NUM_W-1:0]        pa_ff, pb_ff, pc_ff, pd_ff;
   logic [MAG_W-1:0]        ar_ff, au_ff;
   logic                    sr_ff, su_ff;

   logic [NUM_W-1:0]        nxm, nym, dxs, dys;
   logic [NUM_W-1:0]        nm_ff [2];
   logic [NUM_W-1:0]        dn_ff [2];
   logic                    ng_ff [2];
   dlane_type [1:0]         lane_ff;

   assign df = $signed(fi.dot[0]);
   assign dr = $signed(fi.dot[1]);
   assign du = $signed(fi.dot[2]);
   assign af = dot_mag(df);
   assign ar = dot_mag(dr);
   assign au = dot_mag(du);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= fi.valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 4: depth times tangent and the cross products for wrap mode
   always_ff @(posedge clock) begin
      pa_ff <= NUM_W'(af) * NUM_W'(cfg.tan_x);
      pb_ff <= NUM_W'(af) * NUM_W'(cfg.tan_y);
      pc_ff <= NUM_W'(ar) * NUM_W'(cfg.tan_y);
      pd_ff <= NUM_W'(au) * NUM_W'(cfg.tan_x);
      ar_ff <= ar;
      au_ff <= au;
      sr_ff <= dr[DOT_W-1];
      su_ff <= du[DOT_W-1];
      s4_ff.mode    <= fi.mode;
      s4_ff.visible <= fi.mode | (df > DEPTH_MIN);
      s4_ff.behind  <= df[DOT_W-1];
   end

   // stage 5: choose numerator and divisor per axis; wrap tests are strict
   always_comb begin
      nxm = NUM_W'({ar_ff, 16'h0000});
      nym = NUM_W'({au_ff, 16'h0000});
      dxs = pa_ff;
      dys = pb_ff;
      if (s4_ff.mode) begin
         if (nxm > dxs) begin
            nym = pd_ff;
            dys = pc_ff;
         end
         if (nym > dys) begin
            nxm = pc_ff;
            dxs = pd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      nm_ff[0] <= nxm;
      nm_ff[1] <= nym;
      dn_ff[0] <= dxs;
      dn_ff[1] <= dys;
      ng_ff[0] <= sr_ff;
      ng_ff[1] <= su_ff;
      s5_ff    <= s4_ff;
   end

   // stage 6: scale numerators by the half screen extent
   always_ff @(posedge clock) begin
      lane_ff[0].num <= PROD_W'(nm_ff[0]) * PROD_W'(HALF_W16);
      lane_ff[1].num <= PROD_W'(nm_ff[1]) * PROD_W'(HALF_H16);
      lane_ff[0].den <= dn_ff[0];
      lane_ff[1].den <= dn_ff[1];
      lane_ff[0].neg <= ng_ff[0];
      lane_ff[1].neg <= ng_ff[1];
      s6_ff          <= s5_ff;
   end

   assign dout.valid = v6_ff;
   assign dout.side  = s6_ff;
   assign dout.lane  = lane_ff;

endmodule

FILE: src/wptsp_divider.sv
module wptsp_divider import wptsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_in_type   din,
   output div_out_type  dout
);

   localparam int STEPS = Q_W;

   step_type          stg_ff [0:STEPS][2];
   step_type          stg_in [0:STEPS][2];
   logic              vld_ff [0:STEPS];
   side_type          sd_ff  [0:STEPS];

   logic              ov_ff;
   side_type          so_ff;
   qlane_type [1:0]   q_in, q_ff;

   // one restoring step: try the divisor at one quotient bit position
   function automatic step_type div_step(input step_type ln, input logic [3:0] sh);
      step_type         r;
      logic [REM_W-1:0] dsh;
      r   = ln;
      dsh = REM_W'(ln.den) << sh;
      if (ln.rem >= dsh) begin
         r.rem = ln.rem - dsh;
         r.quo = ln.quo | (Q_W'(1) << sh);
      end
      return r;
   endfunction

   always_comb begin
      // entry: quotients of 2^16 or more saturate, a zero numerator gives zero
      for (int l = 0; l < 2; l++) begin
         stg_in[0][l].rem  = REM_W'(din.lane[l].num);
         stg_in[0][l].den  = din.lane[l].den;
         stg_in[0][l].quo  = '0;
         stg_in[0][l].zero = (din.lane[l].num == '0);
         stg_in[0][l].ovf  = (din.lane[l].num != '0) &&
                             (REM_W'(din.lane[l].num) >= (REM_W'(din.lane[l].den) << Q_W));
         stg_in[0][l].neg  = din.lane[l].neg;
      end
      for (int s = 0; s < STEPS; s++) begin
         for (int l = 0; l < 2; l++) begin
            stg_in[s+1][l] = div_step(stg_ff[s][l], 4'(STEPS - 1 - s));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            vld_ff[s] <= 1'b0;
         end
         ov_ff <= 1'b0;
      end else begin
         vld_ff[0] <= din.valid;
         for (int s = 0; s < STEPS; s++) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         ov_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      sd_ff[0] <= din.side;
      for (int s = 0; s < STEPS; s++) begin
         sd_ff[s+1] <= sd_ff[s];
      end
      for (int s = 0; s <= STEPS; s++) begin
         for (int l = 0; l < 2; l++) begin
            stg_ff[s][l] <= stg_in[s][l];
         end
      end
   end

   // round half up on the remainder, saturation flag wins
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_in[l].neg = stg_ff[STEPS][l].neg;
         if (stg_ff[STEPS][l].zero) begin
            q_in[l].quo = '0;
         end else if (stg_ff[STEPS][l].ovf) begin
            q_in[l].quo = (Q_W+1)'(1) << Q_W;
         end else begin
            q_in[l].quo = {1'b0, stg_ff[STEPS][l].quo} +
                          (Q_W+1)'({stg_ff[STEPS][l].rem, 1'b0} >=
                                   (REM_W+1)'(stg_ff[STEPS][l].den));
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff  <= q_in;
      so_ff <= sd_ff[STEPS];
   end

   assign dout.valid = ov_ff;
   assign dout.side  = so_ff;
   assign dout.lane  = q_ff;

endmodule

FILE: src/wptsp_finish.sv
module wptsp_finish import wptsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_out_type  din,
   output result_type   res
);

   logic                     v1_ff, v2_ff;
   side_type                 s1_ff;
   logic signed [SCR_W-1:0]  sx_ff, sy_ff, sx_in, sy_in;
   logic signed [SCR_W-1:0]  ox_ff, oy_ff, ox_in, oy_in;
   logic                     vis_ff;
   logic [SCR_W:0]           ex, ey;

   function automatic logic signed [SCR_W-1:0] place(input logic [K_W-1:0] centre,
                                                     input qlane_type q);
      logic signed [CEN_W-1:0] v;
      if (q.neg) begin
         v = $signed(CEN_W'(centre)) + $signed(CEN_W'(q.quo));
      end else begin
         v = $signed(CEN_W'(centre)) - $signed(CEN_W'(q.quo));
      end
      if (v > $signed(CEN_W'(32767))) begin
         return SCR_W'(32767);
      end else if (v < -$signed(CEN_W'(32768))) begin
         return SCR_W'(-32768);
      end
      return v[SCR_W-1:0];
   endfunction

   assign sx_in = place(HALF_W16, din.lane[0]);
   assign sy_in = place(HALF_H16, din.lane[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= din.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      s1_ff <= din.side;
   end

   // wrap mode edge snap for points behind the viewer inside the screen
   always_comb begin
      ex    = sx_ff >= $signed(SCR_W'(HALF_W16)) ? (SCR_W+1)'(sx_ff - SCR_W'(HALF_W16))
                                                 : (SCR_W+1)'(SCR_W'(HALF_W16) - sx_ff);
      ey    = sy_ff >= $signed(SCR_W'(HALF_H16)) ? (SCR_W+1)'(sy_ff - SCR_W'(HALF_H16))
                                                 : (SCR_W+1)'(SCR_W'(HALF_H16) - sy_ff);
      ox_in = sx_ff;
      oy_in = sy_ff;
      if (!s1_ff.visible) begin
         ox_in = '0;
         oy_in = '0;
      end else if (s1_ff.mode && s1_ff.behind && sx_ff > 0 && sx_ff < FULL_W16 &&
                   sy_ff > 0 && sy_ff < FULL_H16) begin
         if (ex > ey) begin
            ox_in = sx_ff <= $signed(SCR_W'(HALF_W16)) ? '0 : FULL_W16;
         end else begin
            oy_in = sy_ff <= $signed(SCR_W'(HALF_H16)) ? '0 : FULL_H16;
         end
      end
   end

   always_ff @(posedge clock) begin
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      vis_ff <= s1_ff.visible;
   end

   assign res.valid    = v2_ff;
   assign res.visible  = vis_ff;
   assign res.screen_x = ox_ff;
   assign res.screen_y = oy_ff;

endmodule

FILE: src/world_point_to_screen_projection.sv
// Projects world points onto a virtual 640x480 screen in 1/16 pixel. One point
// is taken every clock cycle; busy is high only while reset is held. Each
// result comes out as a single-cycle strobe on rsp_valid, and cannot be
// held off by the receiver. The 16-stage restoring divider, one quotient bit
// per stage, sits behind three stages of dot products and three of operand
// selection and scaling. Configuration writes are always ready and must only
// be issued while no point is in flight.
module world_point_to_screen_projection import wptsp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic signed [PT_W-1:0]   req_point_x,
   input  logic signed [PT_W-1:0]   req_point_y,
   input  logic signed [PT_W-1:0]   req_point_z,
   output logic                     rsp_valid,
   output logic                     rsp_visible,
   output logic signed [SCR_W-1:0]  rsp_screen_x,
   output logic signed [SCR_W-1:0]  rsp_screen_y,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic [3*PT_W-1:0]   origin_ff;
   logic [3*AX_W-1:0]   fwd_ff, right_ff, up_ff;
   logic [TAN_W-1:0]    tanx_ff, tany_ff;
   cfg_type             cfg;
   front_type           fo;
   div_in_type          di;
   div_out_type         dq;
   result_type          res;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         fwd_ff    <= (3*AX_W)'(1) << 18;
         right_ff  <= (3*AX_W)'(1) << 38;
         up_ff     <= (3*AX_W)'(1) << 58;
         tanx_ff   <= TAN_W'(65536);
         tany_ff   <= TAN_W'(49152);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_VIEW_ORIGIN: origin_ff <= csr_wdata[3*PT_W-1:0];
            CSR_FORWARD:     fwd_ff    <= csr_wdata[3*AX_W-1:0];
            CSR_RIGHT:       right_ff  <= csr_wdata[3*AX_W-1:0];
            CSR_UP:          up_ff     <= csr_wdata[3*AX_W-1:0];
            CSR_TAN_X:       tanx_ff   <= csr_wdata[TAN_W-1:0];
            CSR_TAN_Y:       tany_ff   <= csr_wdata[TAN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.origin  = origin_ff;
   assign cfg.axis[0] = fwd_ff;
   assign cfg.axis[1] = right_ff;
   assign cfg.axis[2] = up_ff;
   assign cfg.tan_x   = tanx_ff;
   assign cfg.tan_y   = tany_ff;

   wptsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (start && !busy),
      .in_mode  (req_mode),
      .in_x     (req_point_x),
      .in_y     (req_point_y),
      .in_z     (req_point_z),
      .fo       (fo)
   );

   wptsp_select u_select (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fi    (fo),
      .dout  (di)
   );

   wptsp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .din   (di),
      .dout  (dq)
   );

   wptsp_finish u_finish (
      .clock (clock),
      .reset (reset),
      .din   (dq),
      .res   (res)
   );

   assign rsp_valid    = res.valid;
   assign rsp_visible  = res.visible;
   assign rsp_screen_x = res.screen_x;
   assign rsp_screen_y = res.screen_y;

endmodule

FILE: src/wptsp_checker.sv
module wptsp_checker import wptsp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     req_mode,
   input  logic                     rsp_valid,
   input  logic                     rsp_visible,
   input  logic signed [SCR_W-1:0]  rsp_screen_x,
   input  logic signed [SCR_W-1:0]  rsp_screen_y
);

   // every accepted beat gives a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat produced no result");

   // no result without a beat accepted the latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching beat");

   // a hidden point reports the origin
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_visible) |-> (rsp_screen_x == 0 && rsp_screen_y == 0))
      else $error("hidden point with non-zero coordinates");

   // wrap mode points are always visible
   a_wrap_visible: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode) |-> ##LATENCY rsp_visible)
      else $error("wrap mode point reported hidden");

endmodule

bind world_point_to_screen_projection wptsp_checker u_wptsp_checker (.*);
